@@ sv/hrqs_pkg.sv @@
// Package: types, codes and helpers shared by the HID report queue splitter.
`default_nettype none
package hrqs_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 32;

  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_DRAIN   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic signed [15:0] CLIP_HI = 16'sd127;
  localparam logic signed [15:0] CLIP_LO = -16'sd127;

  localparam logic [5:0] ESC_KEY_CODE  = 6'd41;
  localparam logic [5:0] NO_KEY_CODE   = 6'd0;

  typedef struct packed {
    logic [4:0]         buttons;
    logic               esc;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dw;
    logic signed [15:0] dp;
  } entry_t;

  typedef struct packed {
    logic              enqueue_ok;
    logic              mouse_offered;
    logic              mouse_sent;
    logic [4:0]        buttons;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic signed [7:0] wheel;
    logic signed [7:0] pan;
    logic              escape_offered;
    logic              escape_sent;
    logic [5:0]        escape_key;
    logic              entry_retired;
  } result_t;

  typedef struct packed {
    result_t res;
    entry_t  resid;
    logic    both_done;
    logic    mouse_acked;
    logic    escape_acked;
  } drain_t;

  function automatic logic signed [7:0] clip127(input logic signed [15:0] v);
    logic signed [15:0] c;
    begin
      if (v > CLIP_HI) begin
        c = CLIP_HI;
      end else if (v < CLIP_LO) begin
        c = CLIP_LO;
      end else begin
        c = v;
      end
      return c[7:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ sv/hrqs_entry_ram.sv @@
// Entry memory: one write port, one registered read port.
`default_nettype none
module hrqs_entry_ram #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [IDX_W-1:0]     waddr_i,
  input  wire hrqs_pkg::entry_t     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [IDX_W-1:0]     raddr_i,
  output hrqs_pkg::entry_t          rdata_o
);
  import hrqs_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/hrqs_report_calc.sv @@
// Drain datapath: report clipping, residual deltas and done-flag update.
`default_nettype none
module hrqs_report_calc (
  input  wire hrqs_pkg::entry_t head_i,
  input  wire logic             mouse_done_i,
  input  wire logic             escape_done_i,
  input  wire logic             mouse_accept_i,
  input  wire logic             escape_accept_i,
  output hrqs_pkg::drain_t      drain_o
);
  import hrqs_pkg::*;

  logic signed [7:0] cx, cy, cw, cp;
  logic              m_off, m_sent, e_off, e_sent, m_done, e_done, zero_resid;
  entry_t            resid;

  always_comb begin
    cx = clip127(head_i.dx);
    cy = clip127(head_i.dy);
    cw = clip127(head_i.dw);
    cp = clip127(head_i.dp);
    m_off  = ~mouse_done_i;
    m_sent = m_off & mouse_accept_i;
    e_off  = ~escape_done_i;
    e_sent = e_off & escape_accept_i;
    m_done = mouse_done_i | m_sent;
    e_done = escape_done_i | e_sent;

    resid = head_i;
    if (m_sent) begin
      resid.dx = head_i.dx - 16'(cx);
      resid.dy = head_i.dy - 16'(cy);
      resid.dw = head_i.dw - 16'(cw);
      resid.dp = head_i.dp - 16'(cp);
    end
    zero_resid = (resid.dx == '0) && (resid.dy == '0) && (resid.dw == '0) &&
                 (resid.dp == '0);

    drain_o                    = '0;
    drain_o.resid              = resid;
    drain_o.both_done          = m_done & e_done;
    drain_o.mouse_acked        = m_done;
    drain_o.escape_acked       = e_done;
    drain_o.res.mouse_offered  = m_off;
    drain_o.res.mouse_sent     = m_sent;
    if (m_off) begin
      drain_o.res.buttons = head_i.buttons;
      drain_o.res.dx      = cx;
      drain_o.res.dy      = cy;
      drain_o.res.wheel   = cw;
      drain_o.res.pan     = cp;
    end
    drain_o.res.escape_offered = e_off;
    drain_o.res.escape_sent    = e_sent;
    if (e_off) begin
      drain_o.res.escape_key = head_i.esc ? ESC_KEY_CODE : NO_KEY_CODE;
    end
    drain_o.res.entry_retired  = m_done & e_done & zero_resid;
  end

endmodule
`default_nettype wire

@@ sv/hid_report_queue_splitter_unit.sv @@
// Top level: HID report queue splitter with entry ring in a synchronous memory.
//
//  channel | direction | handshake             | words
//  --------+-----------+-----------------------+-------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | request and enqueued entry fields
//  out     | source    | out_valid_o/out_stall_i | one result word per request
//
//  Each request runs in two steps: accept plus head read, then modify and write back.
//  The registered read port of the entry memory sets this split.
//  A finished result sits in the output register; the next request is taken meanwhile.
//  The second step waits while an earlier result is still stalled at the output.
//  After reset one zero entry is pending; no clearing pass is needed.
`default_nettype none
module hid_report_queue_splitter_unit #(
  parameter int unsigned QUEUE_DEPTH = hrqs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [7:0]        button_bits_i,
  input  wire logic signed [15:0] move_x_i,
  input  wire logic signed [15:0] move_y_i,
  input  wire logic signed [15:0] wheel_move_i,
  input  wire logic signed [15:0] pan_move_i,
  input  wire logic              escape_pressed_i,
  input  wire logic              mouse_accept_i,
  input  wire logic              escape_accept_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   enqueue_ok_o,
  output logic                   mouse_offered_o,
  output logic                   mouse_sent_o,
  output logic [4:0]             report_buttons_o,
  output logic signed [7:0]      report_dx_o,
  output logic signed [7:0]      report_dy_o,
  output logic signed [7:0]      report_wheel_o,
  output logic signed [7:0]      report_pan_o,
  output logic                   escape_offered_o,
  output logic                   escape_sent_o,
  output logic [5:0]             escape_key_o,
  output logic                   entry_retired_o
);
  import hrqs_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d, wr_nxt, rd_nxt;
  logic             mouse_done_q, mouse_done_d, esc_done_q, esc_done_d;
  logic             zero_head_q, zero_head_d;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  logic [1:0]  req_q;
  entry_t      item_q;
  logic        m_acc_q, e_acc_q;

  logic             in_acc, exec_go, full, empty;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata, rdata, head;
  drain_t           drain;

  assign in_stall_o = (state_q == ST_EXEC);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign exec_go    = (state_q == ST_EXEC) & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q          <= req_type_i;
      item_q.buttons <= button_bits_i[4:0];
      item_q.esc     <= escape_pressed_i;
      item_q.dx      <= move_x_i;
      item_q.dy      <= move_y_i;
      item_q.dw      <= wheel_move_i;
      item_q.dp      <= pan_move_i;
      m_acc_q        <= mouse_accept_i;
      e_acc_q        <= escape_accept_i;
    end
  end

  hrqs_entry_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (in_acc),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  assign head = (zero_head_q && (rd_idx_q == '0)) ? entry_t'('0) : rdata;

  hrqs_report_calc u_calc (
    .head_i          (head),
    .mouse_done_i    (mouse_done_q),
    .escape_done_i   (esc_done_q),
    .mouse_accept_i  (m_acc_q),
    .escape_accept_i (e_acc_q),
    .drain_o         (drain)
  );

  assign wr_nxt = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + IDX_ONE;
  assign rd_nxt = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + IDX_ONE;
  assign full   = (wr_nxt == rd_idx_q);
  assign empty  = (rd_idx_q == wr_idx_q);

  always_comb begin
    state_d      = state_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    mouse_done_d = mouse_done_q;
    esc_done_d   = esc_done_q;
    zero_head_d  = zero_head_q;
    res_d        = '0;
    we           = 1'b0;
    waddr        = wr_idx_q;
    wdata        = item_q;
    out_valid_d  = out_valid_q & out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          case (req_q)
            REQ_ENQUEUE: begin
              if (full) begin
                wr_idx_d     = IDX_ONE;
                rd_idx_d     = '0;
                mouse_done_d = 1'b0;
                esc_done_d   = 1'b0;
                zero_head_d  = 1'b1;
              end else begin
                we               = 1'b1;
                wr_idx_d         = wr_nxt;
                res_d.enqueue_ok = 1'b1;
                if (wr_idx_q == '0) begin
                  zero_head_d = 1'b0;
                end
              end
            end
            REQ_DRAIN: begin
              if (!empty) begin
                res_d = drain.res;
                if (drain.res.mouse_sent) begin
                  we    = 1'b1;
                  waddr = rd_idx_q;
                  wdata = drain.resid;
                  if (rd_idx_q == '0) begin
                    zero_head_d = 1'b0;
                  end
                end
                if (drain.both_done) begin
                  mouse_done_d = 1'b0;
                  esc_done_d   = 1'b0;
                end else begin
                  mouse_done_d = drain.mouse_acked;
                  esc_done_d   = drain.escape_acked;
                end
                if (drain.res.entry_retired) begin
                  rd_idx_d = rd_nxt;
                end
              end
            end
            REQ_RELEASE: begin
              wr_idx_d     = IDX_ONE;
              rd_idx_d     = '0;
              mouse_done_d = 1'b0;
              esc_done_d   = 1'b0;
              zero_head_d  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wr_idx_q     <= IDX_ONE;
      rd_idx_q     <= '0;
      mouse_done_q <= 1'b0;
      esc_done_q   <= 1'b0;
      zero_head_q  <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      mouse_done_q <= mouse_done_d;
      esc_done_q   <= esc_done_d;
      zero_head_q  <= zero_head_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign enqueue_ok_o     = res_q.enqueue_ok;
  assign mouse_offered_o  = res_q.mouse_offered;
  assign mouse_sent_o     = res_q.mouse_sent;
  assign report_buttons_o = res_q.buttons;
  assign report_dx_o      = res_q.dx;
  assign report_dy_o      = res_q.dy;
  assign report_wheel_o   = res_q.wheel;
  assign report_pan_o     = res_q.pan;
  assign escape_offered_o = res_q.escape_offered;
  assign escape_sent_o    = res_q.escape_sent;
  assign escape_key_o     = res_q.escape_key;
  assign entry_retired_o  = res_q.entry_retired;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_idx_q <= IDX_LAST) && (wr_idx_q <= IDX_LAST))
    else $error("ring index out of range");

  a_exec_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("completed request did not produce a word");

  a_retire_moves_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && res_d.entry_retired |=> rd_idx_q != $past(rd_idx_q))
    else $error("retired entry left head unchanged");

  a_done_clear_on_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go && res_d.entry_retired |=> !mouse_done_q && !esc_done_q)
    else $error("done flags survived retirement");

  a_sent_needs_offer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mouse_sent_o || escape_sent_o) |->
      (!mouse_sent_o || mouse_offered_o) && (!escape_sent_o || escape_offered_o))
    else $error("report sent without offer");
`endif

endmodule
`default_nettype wire
